>>> hdl/dsdv_pkg.sv
package dsdv_pkg;

    localparam int DEST_COUNT_DEF = 32;
    localparam int ID_W           = 5;
    localparam int SEQ_W          = 16;
    localparam int COST_W         = 16;
    localparam int FUNC_W         = 2;
    localparam int S_DATA_W       = 64;
    localparam int M_DATA_W       = 48;

    localparam logic [FUNC_W-1:0] FUNC_ADV   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [COST_W-1:0] cost;
        logic              reach;
        logic [ID_W-1:0]   hop;
    } route_t;

    typedef struct packed {
        route_t s1;
        route_t s0;
    } row_t;

    typedef struct packed {
        logic              last;
        logic              chg;
        logic [ID_W-1:0]   hop;
        logic              reach;
        logic [COST_W-1:0] cost;
        logic [SEQ_W-1:0]  seq;
        logic [ID_W-1:0]   dest;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_SW_RD,
        ST_SW_EXEC,
        ST_SW_SLOT,
        ST_SW_END
    } state_t;

    function automatic logic cheaper(input logic ra, input logic [COST_W-1:0] ca,
                                     input logic rb, input logic [COST_W-1:0] cb);
        logic res;
        if (!ra) begin
            res = 1'b0;
        end else if (!rb) begin
            res = 1'b1;
        end else begin
            res = (ca < cb);
        end
        return res;
    endfunction

endpackage

>>> hdl/dsdv_route_table_update.sv
// Advertisement and query: the table row is read (ST_RD), then updated and written or answered
// (ST_EXEC) into the output register; the next input is taken back in idle; an ignored item stays idle.
// Link-down sweep: each destination row is read, updated, then its two slots are stepped, and a
// final step ends it; both can wait on a stalled output; one table address serves read and write.
// Reset (synchronous, active low) clears control, self_id and the per-row valid flags at once;
// a row not written since reset reads as sequence 0, cost 0, unreachable, next hop 0.
module dsdv_route_table_update
    import dsdv_pkg::*;
#(
    parameter int DEST_COUNT = DEST_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [ID_W-1:0]     cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // neighbor, link_cost, link_up, dest, adv_seq, adv_cost, adv_reachable
    input  logic [S_DATA_W-1:0] s_tdata,
    // func
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_dest, out_seq, out_cost, out_reachable, out_next_hop
    output logic [M_DATA_W-1:0] m_tdata,
    // is_change
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int AW = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
    localparam int DW = (AW > ID_W) ? AW : ID_W;
    localparam int CW = 9;

    state_t              state_reg, state_next;
    logic [ID_W-1:0]     self_id_reg;

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [ID_W-1:0]     nb_reg, nb_next;
    logic [COST_W-1:0]   lcost_reg, lcost_next;
    logic                lup_reg, lup_next;
    logic [ID_W-1:0]     dest_reg, dest_next;
    logic [SEQ_W-1:0]    aseq_reg, aseq_next;
    logic [COST_W-1:0]   acost_reg, acost_next;
    logic                areach_reg, areach_next;
    logic                oor_reg, oor_next;
    logic [COST_W-1:0]   nc_reg, nc_next;
    logic                nr_reg, nr_next;

    logic [AW-1:0]       addr_reg, addr_next;
    logic                sub_reg, sub_next;
    logic                m0_reg, m0_next, m1_reg, m1_next;
    result_t             cand0_reg, cand0_next, cand1_reg, cand1_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;

    logic                m_valid_reg, m_valid_next;
    result_t             m_data_reg, m_data_next;

    row_t                mem [DEST_COUNT];
    logic [DEST_COUNT-1:0] row_valid_reg;
    row_t                rd_data_reg;
    logic                rd_valid_reg;
    logic                mem_we;
    row_t                mem_wdata;

    logic                s_fire, out_free;
    logic [ID_W-1:0]     in_nb, in_dest;
    logic [AW-1:0]       in_idx;
    logic                in_oor;
    row_t                cur_row, adv_row, sw_row;
    route_t              new_route;
    logic                adv_dirty;
    logic                exec_need_out, exec_stall;
    logic                slot_m, slot_stall, sw_last_row;
    logic [COST_W:0]     cost_sum;

    assign in_nb    = s_tdata[4:0];
    assign in_dest  = s_tdata[26:22];
    assign in_idx   = DW'(in_dest) >> 0 == '0 ? '0 : AW'(DW'(in_dest));
    assign in_oor   = (CW'(in_dest) >= CW'(DEST_COUNT));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cur_row  = rd_valid_reg ? rd_data_reg : '0;
    assign cost_sum = {1'b0, lcost_reg} + {1'b0, acost_reg};

    assign new_route = '{seq: aseq_reg, cost: nc_reg, reach: nr_reg, hop: nb_reg};

    always_comb begin
        adv_row   = cur_row;
        adv_dirty = 1'b0;
        if (aseq_reg > cur_row.s0.seq) begin
            adv_row.s1 = aseq_reg[0] ? new_route : cur_row.s0;
            adv_row.s0 = new_route;
            adv_dirty  = 1'b1;
        end else begin
            if (aseq_reg == cur_row.s0.seq &&
                cheaper(nr_reg, nc_reg, cur_row.s0.reach, cur_row.s0.cost)) begin
                adv_row.s0 = new_route;
                adv_dirty  = 1'b1;
            end
            if (aseq_reg == cur_row.s1.seq &&
                cheaper(nr_reg, nc_reg, cur_row.s1.reach, cur_row.s1.cost)) begin
                adv_row.s1 = new_route;
                adv_dirty  = 1'b1;
            end
        end
    end

    always_comb begin
        sw_row = cur_row;
        if (cur_row.s0.reach && cur_row.s0.hop == nb_reg) begin
            sw_row.s0.reach = 1'b0;
            sw_row.s0.cost  = '0;
            sw_row.s0.seq   = cur_row.s0.seq + SEQ_W'(1);
        end
        if (cur_row.s1.reach && cur_row.s1.hop == nb_reg) begin
            sw_row.s1.reach = 1'b0;
            sw_row.s1.cost  = '0;
            sw_row.s1.seq   = cur_row.s1.seq + SEQ_W'(1);
        end
    end

    assign exec_need_out = (func_reg == FUNC_QUERY) || adv_dirty;
    assign exec_stall    = exec_need_out && !out_free;
    assign slot_m        = sub_reg ? m1_reg : m0_reg;
    assign slot_stall    = slot_m && pend_valid_reg && !out_free;
    assign sw_last_row   = (addr_reg == AW'(DEST_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        FUNC_ADV: begin
                            if (in_dest != self_id_reg && !in_oor) begin
                                state_next = ST_RD;
                            end
                        end
                        FUNC_SWEEP: state_next = ST_SW_RD;
                        FUNC_QUERY: state_next = ST_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:      state_next = ST_EXEC;
            ST_EXEC: begin
                if (!exec_stall) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD:   state_next = ST_SW_EXEC;
            ST_SW_EXEC: state_next = ST_SW_SLOT;
            ST_SW_SLOT: begin
                if (!slot_stall && sub_reg) begin
                    state_next = sw_last_row ? ST_SW_END : ST_SW_RD;
                end
            end
            ST_SW_END: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        func_next       = func_reg;
        nb_next         = nb_reg;
        lcost_next      = lcost_reg;
        lup_next        = lup_reg;
        dest_next       = dest_reg;
        aseq_next       = aseq_reg;
        acost_next      = acost_reg;
        areach_next     = areach_reg;
        oor_next        = oor_reg;
        nc_next         = nc_reg;
        nr_next         = nr_reg;
        addr_next       = addr_reg;
        sub_next        = sub_reg;
        m0_next         = m0_reg;
        m1_next         = m1_reg;
        cand0_next      = cand0_reg;
        cand1_next      = cand1_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_wdata       = adv_row;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    func_next       = s_tuser;
                    nb_next         = in_nb;
                    lcost_next      = s_tdata[20:5];
                    lup_next        = s_tdata[21];
                    dest_next       = in_dest;
                    aseq_next       = s_tdata[42:27];
                    acost_next      = s_tdata[58:43];
                    areach_next     = s_tdata[59];
                    oor_next        = in_oor;
                    addr_next       = (s_tuser == FUNC_SWEEP) ? '0 : in_idx;
                    sub_next        = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_RD: begin
                nr_next = lup_reg && areach_reg;
                if (!(lup_reg && areach_reg)) begin
                    nc_next = '0;
                end else if (cost_sum[COST_W]) begin
                    nc_next = COST_MAX;
                end else begin
                    nc_next = cost_sum[COST_W-1:0];
                end
            end
            ST_EXEC: begin
                if (!exec_stall) begin
                    if (func_reg == FUNC_QUERY) begin
                        m_data_next.dest = dest_reg;
                        m_data_next.chg  = 1'b0;
                        m_data_next.last = 1'b1;
                        if (oor_reg) begin
                            m_data_next.seq   = '0;
                            m_data_next.cost  = '0;
                            m_data_next.reach = 1'b0;
                            m_data_next.hop   = '0;
                        end else if (cheaper(cur_row.s1.reach, cur_row.s1.cost,
                                             cur_row.s0.reach, cur_row.s0.cost)) begin
                            m_data_next.seq   = cur_row.s1.seq;
                            m_data_next.cost  = cur_row.s1.reach ? cur_row.s1.cost : '0;
                            m_data_next.reach = cur_row.s1.reach;
                            m_data_next.hop   = cur_row.s1.hop;
                        end else begin
                            m_data_next.seq   = cur_row.s0.seq;
                            m_data_next.cost  = cur_row.s0.reach ? cur_row.s0.cost : '0;
                            m_data_next.reach = cur_row.s0.reach;
                            m_data_next.hop   = cur_row.s0.hop;
                        end
                        m_valid_next = 1'b1;
                    end else if (adv_dirty) begin
                        mem_we       = 1'b1;
                        mem_wdata    = adv_row;
                        m_data_next  = '{last: 1'b1, chg: 1'b1, hop: nb_reg, reach: nr_reg,
                                         cost: nc_reg, seq: aseq_reg, dest: dest_reg};
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_SW_EXEC: begin
                mem_we     = 1'b1;
                mem_wdata  = sw_row;
                m0_next    = cur_row.s0.reach && cur_row.s0.hop == nb_reg;
                m1_next    = cur_row.s1.reach && cur_row.s1.hop == nb_reg;
                cand0_next = '{last: 1'b0, chg: 1'b1, hop: sw_row.s0.hop, reach: 1'b0,
                               cost: '0, seq: sw_row.s0.seq,
                               dest: DW'(addr_reg) >> 0 == '0 ? '0 : ID_W'(DW'(addr_reg))};
                cand1_next = '{last: 1'b0, chg: 1'b1, hop: sw_row.s1.hop, reach: 1'b0,
                               cost: '0, seq: sw_row.s1.seq,
                               dest: DW'(addr_reg) >> 0 == '0 ? '0 : ID_W'(DW'(addr_reg))};
            end
            ST_SW_SLOT: begin
                if (!slot_stall) begin
                    if (slot_m) begin
                        if (pend_valid_reg) begin
                            m_data_next  = pend_reg;
                            m_valid_next = 1'b1;
                        end
                        pend_next       = sub_reg ? cand1_reg : cand0_reg;
                        pend_valid_next = 1'b1;
                    end
                    sub_next = !sub_reg;
                    if (sub_reg && !sw_last_row) begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end
            ST_SW_END: begin
                if (pend_valid_reg && out_free) begin
                    m_data_next      = pend_reg;
                    m_data_next.last = 1'b1;
                    m_valid_next     = 1'b1;
                    pend_valid_next  = 1'b0;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            self_id_reg    <= '0;
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            sub_reg        <= 1'b0;
            addr_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                self_id_reg <= cfg_wr_data;
            end
            if (mem_we) begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
            rd_valid_reg   <= row_valid_reg[addr_reg];
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            sub_reg        <= sub_next;
            addr_reg       <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        nb_reg     <= nb_next;
        lcost_reg  <= lcost_next;
        lup_reg    <= lup_next;
        dest_reg   <= dest_next;
        aseq_reg   <= aseq_next;
        acost_reg  <= acost_next;
        areach_reg <= areach_next;
        oor_reg    <= oor_next;
        nc_reg     <= nc_next;
        nr_reg     <= nr_next;
        m0_reg     <= m0_next;
        m1_reg     <= m1_next;
        cand0_reg  <= cand0_next;
        cand1_reg  <= cand1_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg.hop, m_data_reg.reach, m_data_reg.cost,
                       m_data_reg.seq, m_data_reg.dest};
    assign m_tuser  = m_data_reg.chg;
    assign m_tlast  = m_data_reg.last;

endmodule

>>> bench/dsdv_route_table_update_tb.sv
`timescale 1ns / 1ps

module dsdv_route_table_update_tb;
    import dsdv_pkg::*;

    localparam int          SLOTS           = 2 * DEST_COUNT_DEF;
    localparam int unsigned SETTLE_CYCLES   = 200;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   neighbor;
        logic [COST_W-1:0] link_cost;
        logic              link_up;
        logic [ID_W-1:0]   dest;
        logic [SEQ_W-1:0]  adv_seq;
        logic [COST_W-1:0] adv_cost;
        logic              adv_reach;
    } route_cmd_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [ID_W-1:0]     cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    route_t          route_table [SLOTS];
    logic [ID_W-1:0] self_id_model;
    result_t         route_expect_q [$];
    int unsigned     fail_count     = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     hold_off_reqs  = 0;

    dsdv_route_table_update u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic beats(input route_t a, input route_t b);
        if (!a.reach) begin
            return 1'b0;
        end
        if (!b.reach) begin
            return 1'b1;
        end
        return a.cost < b.cost;
    endfunction

    function automatic result_t route_result(input logic [ID_W-1:0] dest, input route_t rt,
                                             input logic chg, input logic last);
        result_t r;
        r.dest  = dest;
        r.seq   = rt.seq;
        r.cost  = rt.reach ? rt.cost : '0;
        r.reach = rt.reach;
        r.hop   = rt.hop;
        r.chg   = chg;
        r.last  = last;
        return r;
    endfunction

    function automatic void predict_routes(input route_cmd_t c);
        int          s0;
        int          pick;
        int unsigned sum;
        route_t      fresh;
        logic        dirty;
        logic        pending_valid;
        result_t     pending;
        s0 = 2 * int'(c.dest);
        case (c.func)
            FUNC_ADV: begin
                if (c.dest != self_id_model) begin
                    sum         = 32'(c.link_cost) + 32'(c.adv_cost);
                    fresh.seq   = c.adv_seq;
                    fresh.reach = c.link_up && c.adv_reach;
                    fresh.cost  = !fresh.reach ? '0 : (sum > 32'hFFFF ? COST_MAX : sum[15:0]);
                    fresh.hop   = c.neighbor;
                    dirty       = 1'b0;
                    if (c.adv_seq > route_table[s0].seq) begin
                        route_table[s0 + 1] = c.adv_seq[0] ? fresh : route_table[s0];
                        route_table[s0]     = fresh;
                        dirty               = 1'b1;
                    end else begin
                        for (int j = 0; j < 2; j++) begin
                            if (c.adv_seq == route_table[s0 + j].seq &&
                                beats(fresh, route_table[s0 + j])) begin
                                route_table[s0 + j] = fresh;
                                dirty               = 1'b1;
                            end
                        end
                    end
                    if (dirty) begin
                        route_expect_q.push_back(route_result(c.dest, fresh, 1'b1, 1'b1));
                    end
                end
            end
            FUNC_SWEEP: begin
                pending_valid = 1'b0;
                pending       = '0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (route_table[s].reach && route_table[s].hop == c.neighbor) begin
                        route_table[s].reach = 1'b0;
                        route_table[s].cost  = '0;
                        route_table[s].seq   = route_table[s].seq + 16'd1;
                        if (pending_valid) begin
                            route_expect_q.push_back(pending);
                        end
                        pending       = route_result(ID_W'(s / 2), route_table[s], 1'b1, 1'b0);
                        pending_valid = 1'b1;
                    end
                end
                if (pending_valid) begin
                    pending.last = 1'b1;
                    route_expect_q.push_back(pending);
                end
            end
            FUNC_QUERY: begin
                pick = beats(route_table[s0 + 1], route_table[s0]) ? s0 + 1 : s0;
                route_expect_q.push_back(route_result(c.dest, route_table[pick], 1'b0, 1'b1));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic route_cmd_t make_cmd(input logic [FUNC_W-1:0] func,
                                            input logic [ID_W-1:0] neighbor,
                                            input logic [COST_W-1:0] link_cost,
                                            input logic link_up,
                                            input logic [ID_W-1:0] dest,
                                            input logic [SEQ_W-1:0] adv_seq,
                                            input logic [COST_W-1:0] adv_cost,
                                            input logic adv_reach);
        route_cmd_t c;
        c.func      = func;
        c.neighbor  = neighbor;
        c.link_cost = link_cost;
        c.link_up   = link_up;
        c.dest      = dest;
        c.adv_seq   = adv_seq;
        c.adv_cost  = adv_cost;
        c.adv_reach = adv_reach;
        return c;
    endfunction

    function automatic route_cmd_t random_cmd();
        route_cmd_t       c;
        int unsigned      pick;
        logic [SEQ_W-1:0] base;
        c.func      = FUNC_W'($urandom);
        c.neighbor  = ID_W'($urandom);
        c.link_cost = COST_W'($urandom);
        c.link_up   = 1'($urandom);
        c.dest      = ID_W'($urandom);
        c.adv_seq   = SEQ_W'($urandom);
        c.adv_cost  = COST_W'($urandom);
        c.adv_reach = 1'($urandom);
        pick        = $urandom_range(99);
        if (pick < 55) begin
            // well-formed advertisement close to the stored sequence numbers
            c.func = FUNC_ADV;
            if ($urandom_range(9) < 7) begin
                c.dest = ID_W'($urandom_range(7));
            end
            if ($urandom_range(4) != 0) begin
                c.neighbor = ID_W'($urandom_range(3));
            end
            c.link_up   = ($urandom_range(9) != 0);
            c.adv_reach = ($urandom_range(9) != 0);
            base        = route_table[{c.dest, 1'($urandom)}].seq;
            c.adv_seq   = base + SEQ_W'($urandom_range(3)) - 16'd1;
            if ($urandom_range(9) != 0) begin
                c.link_cost = COST_W'($urandom_range(16'h0fff));
                c.adv_cost  = COST_W'($urandom_range(16'h0fff));
            end
        end else if (pick < 63) begin
            c.func = FUNC_ADV;
        end else if (pick < 73) begin
            c.func = FUNC_SWEEP;
            if ($urandom_range(4) != 0) begin
                c.neighbor = ID_W'($urandom_range(3));
            end
        end else if (pick < 95) begin
            c.func = FUNC_QUERY;
            if ($urandom_range(9) < 7) begin
                c.dest = ID_W'($urandom_range(7));
            end
        end else begin
            c.func = FUNC_NONE;
        end
        return c;
    endfunction

    task automatic send_cmd(input route_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.func;
        s_tdata  <= {4'b0, c.adv_reach, c.adv_cost, c.adv_seq, c.dest, c.link_up,
                     c.link_cost, c.neighbor};
        do @(posedge aclk); while (!s_tready);
        predict_routes(c);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (route_expect_q.size() != 0);
    endtask

    task automatic set_self_id(input logic [ID_W-1:0] id);
        wait_drained();
        // let a sweep with no further transfers finish its walk
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        self_id_model = id;
    endtask

    task automatic test_reset_state();
        send_cmd(make_cmd(FUNC_SWEEP, 5'd0, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd31, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd12, 16'd0, 16'd0, 1'b0));
    endtask

    task automatic test_directed();
        send_cmd(make_cmd(FUNC_ADV, 5'd2, 16'h0100, 1'b1, 5'd1, 16'd2, 16'h0200, 1'b1));
        // saturating sum, odd sequence
        send_cmd(make_cmd(FUNC_ADV, 5'd3, 16'hFFFF, 1'b1, 5'd1, 16'd3, 16'hFFFF, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd4, 16'h0010, 1'b1, 5'd1, 16'd3, 16'h0001, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd5, 16'h0100, 1'b1, 5'd1, 16'd3, 16'h0100, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd5, 16'h0001, 1'b1, 5'd1, 16'd1, 16'h0001, 1'b1));
        // unreachable via broken link, then via infinite advertised cost
        send_cmd(make_cmd(FUNC_ADV, 5'd2, 16'h0300, 1'b0, 5'd2, 16'd4, 16'h0300, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd6, 16'h0300, 1'b1, 5'd2, 16'd4, 16'h0300, 1'b0));
        send_cmd(make_cmd(FUNC_ADV, 5'd2, 16'h0000, 1'b1, 5'd2, 16'd4, 16'h0000, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd9, 16'h0001, 1'b1, 5'd0, 16'd8, 16'h0001, 1'b1));
        send_cmd(make_cmd(FUNC_NONE, 5'd2, 16'h0001, 1'b1, 5'd1, 16'd9, 16'h0001, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd31, 16'h0000, 1'b1, 5'd31, 16'hFFFF, 16'h0000, 1'b1));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd1, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd31, 16'd0, 16'd0, 1'b0));
        // older route kept in the second slot ends up cheaper
        send_cmd(make_cmd(FUNC_ADV, 5'd7, 16'h0200, 1'b1, 5'd3, 16'd6, 16'h0300, 1'b1));
        send_cmd(make_cmd(FUNC_ADV, 5'd8, 16'h0800, 1'b1, 5'd3, 16'd8, 16'h0100, 1'b1));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd3, 16'd0, 16'd0, 1'b0));
        // sequence wraps on sweep
        send_cmd(make_cmd(FUNC_SWEEP, 5'd31, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_SWEEP, 5'd9, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_SWEEP, 5'd2, 16'd0, 1'b0, 5'd0, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd31, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_ADV, 5'd1, 16'h1234, 1'b1, 5'd31, 16'd0, 16'h4321, 1'b1));
    endtask

    task automatic test_self_id();
        set_self_id(5'd5);
        send_cmd(make_cmd(FUNC_ADV, 5'd1, 16'h0001, 1'b1, 5'd5, 16'd4, 16'h0001, 1'b1));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd5, 16'd0, 16'd0, 1'b0));
        send_cmd(make_cmd(FUNC_ADV, 5'd1, 16'h0001, 1'b1, 5'd0, 16'd4, 16'h0001, 1'b1));
        set_self_id(5'd31);
        send_cmd(make_cmd(FUNC_ADV, 5'd3, 16'h0002, 1'b1, 5'd31, 16'd6, 16'h0002, 1'b1));
        send_cmd(make_cmd(FUNC_QUERY, 5'd0, 16'd0, 1'b0, 5'd31, 16'd0, 16'd0, 1'b0));
    endtask

    task automatic test_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        route_cmd_t  c;
        int unsigned counted;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        counted        = 0;
        while (counted < n_items) begin
            c = random_cmd();
            if (c.func != FUNC_NONE && !(c.func == FUNC_ADV && c.dest == self_id_model)) begin
                counted++;
            end
            send_cmd(c);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_off_reqs++;
        repeat (30) send_cmd(random_cmd());
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (8) send_cmd(random_cmd());
        wait_drained();
        repeat (8) send_cmd(random_cmd());
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'({m_tlast, m_tuser, m_tdata[$bits(result_t)-3:0]});
            if (route_expect_q.size() == 0) begin
                $error("unexpected result transfer: dest %0d seq %0d", got.dest, got.seq);
                fail_count++;
            end else begin
                want = route_expect_q.pop_front();
                check_field("out_dest", 32'(want.dest), 32'(got.dest));
                check_field("out_seq", 32'(want.seq), 32'(got.seq));
                check_field("out_cost", 32'(want.cost), 32'(got.cost));
                check_field("out_reachable", 32'(want.reach), 32'(got.reach));
                check_field("out_next_hop", 32'(want.hop), 32'(got.hop));
                check_field("is_change", 32'(want.chg), 32'(got.chg));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        foreach (route_table[i]) begin
            route_table[i] = '0;
        end
        self_id_model = '0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_directed();
        test_self_id();
        test_random_phase(85, 0, 0);
        test_backpressure();
        set_self_id(5'd0);
        test_random_phase(85, 70, 0);
        test_random_phase(85, 0, 70);
        set_self_id(5'd17);
        test_random_phase(85, 12, 12);
        test_drain_pause();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/dsdv_pkg.sv
hdl/dsdv_route_table_update.sv
bench/dsdv_route_table_update_tb.sv
